### rtl/swve_pkg.sv
package swve_pkg;

  // Field widths fixed by the interface.
  localparam int PIX_W   = 11;
  localparam int XW      = 12;
  localparam int TW      = 32;
  localparam int TPS_W   = 32;
  localparam int VEL_W   = 32;
  localparam int Q_FRAC  = 8;

  // Shared multiplier: 33 x 33 signed, wide operands go through it in 32 bit limbs.
  localparam int LIMB_W  = 32;
  localparam int OPND_W  = 33;
  localparam int PROD_W  = 66;

  // Saturation bounds of the velocity.
  localparam logic [VEL_W-1:0] VEL_MAX = 32'h7FFF_FFFF;
  localparam logic [VEL_W-1:0] VEL_MIN = 32'h8000_0000;

  // Length of the fixed multiply program that forms num, den and the dividend.
  localparam int PROG_LEN   = 13;
  localparam int PROG_CNT_W = 4;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_TPS    = 2'd0,
    REG_CENTRE = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_PROG,
    ST_DRAIN,
    ST_DSTART,
    ST_DIV,
    ST_SHIFT,
    ST_OUT
  } state_t;

  // Multiplier operand selects.
  typedef enum logic [3:0] {
    A_D,
    A_ABSD,
    A_SDX_LO,
    A_SDX_HI,
    A_SD_LO,
    A_SD_HI,
    A_SDD_L0,
    A_SDD_L1,
    A_SDD_L2,
    A_NUM_LO,
    A_NUM_HI
  } opa_t;

  typedef enum logic [2:0] {
    B_X,
    B_ABSD,
    B_N,
    B_SX,
    B_SD_LO,
    B_SD_HI,
    B_TPS
  } opb_t;

  // Where a product is accumulated.
  typedef enum logic [1:0] {
    DST_NONE,
    DST_SDX,
    DST_SDD,
    DST_ACC
  } dest_t;

  // What the accumulator holds when a section restarts it.
  typedef enum logic [1:0] {
    SV_NONE,
    SV_NUM,
    SV_DEN
  } save_t;

  // One multiply slot of the sequencer.
  typedef struct packed {
    opa_t        a;
    opb_t        b;
    logic [1:0]  sh;
    dest_t       dst;
    logic        sub;
    logic        clr;
    save_t       save;
  } mop_t;

  // Window control.
  typedef struct packed {
    logic rotate;
    logic push;
  } win_ctrl_t;

  // Divider request.
  typedef struct packed {
    logic start;
    logic neg;
  } div_req_t;

  // Multiply program:
  //   slots 0..3   num = N*sdx - sd*sx
  //   slots 4..10  den = N*sdd - sd*sd   (restart saves num)
  //   slots 11..12 mag = |num| * ticks  (restart saves den)
  function automatic mop_t prog_op(input logic [PROG_CNT_W-1:0] idx);
    mop_t m;
    m = '{a: A_D, b: B_X, sh: 2'd0, dst: DST_NONE, sub: 1'b0, clr: 1'b0, save: SV_NONE};
    case (idx)
      4'd0: m = '{a: A_SDX_LO, b: B_N, sh: 2'd0, dst: DST_ACC, sub: 1'b0, clr: 1'b1,
                  save: SV_NONE};
      4'd1: m = '{a: A_SDX_HI, b: B_N, sh: 2'd1, dst: DST_ACC, sub: 1'b0, clr: 1'b0,
                  save: SV_NONE};
      4'd2: m = '{a: A_SD_LO, b: B_SX, sh: 2'd0, dst: DST_ACC, sub: 1'b1, clr: 1'b0,
                  save: SV_NONE};
      4'd3: m = '{a: A_SD_HI, b: B_SX, sh: 2'd1, dst: DST_ACC, sub: 1'b1, clr: 1'b0,
                  save: SV_NONE};
      4'd4: m = '{a: A_SDD_L0, b: B_N, sh: 2'd0, dst: DST_ACC, sub: 1'b0, clr: 1'b1,
                  save: SV_NUM};
      4'd5: m = '{a: A_SDD_L1, b: B_N, sh: 2'd1, dst: DST_ACC, sub: 1'b0, clr: 1'b0,
                  save: SV_NONE};
      4'd6: m = '{a: A_SDD_L2, b: B_N, sh: 2'd2, dst: DST_ACC, sub: 1'b0, clr: 1'b0,
                  save: SV_NONE};
      4'd7: m = '{a: A_SD_LO, b: B_SD_LO, sh: 2'd0, dst: DST_ACC, sub: 1'b1, clr: 1'b0,
                  save: SV_NONE};
      4'd8: m = '{a: A_SD_LO, b: B_SD_HI, sh: 2'd1, dst: DST_ACC, sub: 1'b1, clr: 1'b0,
                  save: SV_NONE};
      4'd9: m = '{a: A_SD_LO, b: B_SD_HI, sh: 2'd1, dst: DST_ACC, sub: 1'b1, clr: 1'b0,
                  save: SV_NONE};
      4'd10: m = '{a: A_SD_HI, b: B_SD_HI, sh: 2'd2, dst: DST_ACC, sub: 1'b1, clr: 1'b0,
                   save: SV_NONE};
      4'd11: m = '{a: A_NUM_LO, b: B_TPS, sh: 2'd0, dst: DST_ACC, sub: 1'b0, clr: 1'b1,
                   save: SV_DEN};
      4'd12: m = '{a: A_NUM_HI, b: B_TPS, sh: 2'd1, dst: DST_ACC, sub: 1'b0, clr: 1'b0,
                   save: SV_NONE};
      default: m = '{a: A_D, b: B_X, sh: 2'd0, dst: DST_NONE, sub: 1'b0, clr: 1'b0,
                     save: SV_NONE};
    endcase
    return m;
  endfunction

endpackage

### rtl/sliding_window_velocity_estimator.sv
// A word without a detection goes straight to the window update and the result; a detected
// word first runs the per-sample loop, the multiply program and the divide, which is skipped
// if all window times are equal. Throughput: one word at a time; the next word is taken in
// the cycle after the result leaves.
// Reset: synchronous active-low rst_n clears the window and restores the registers.
module sliding_window_velocity_estimator import swve_pkg::*; #(
  parameter int WINDOW_LENGTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // pixel_x[10:0], pixel_y[21:11], timestamp[53:22]
  input  logic [0:0]  in_tuser,   // found[0]
  // Result words.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // centred_x[11:0], flipped_y[23:12], velocity_x[55:24]
  // Register writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int LW     = $clog2(WINDOW_LENGTH + 1);
  localparam int SD_W   = 33 + LW;
  localparam int SX_W   = XW + LW;
  localparam int SDX_W  = 45 + LW;
  localparam int SDD_W  = 64 + LW;
  localparam int NUM_W  = 46 + 2 * LW;
  localparam int DEN_W  = 65 + 2 * LW;
  localparam int MAG_W  = NUM_W + LIMB_W;
  localparam int ACC_W  = MAG_W + 1;
  localparam int DVD_W  = MAG_W + Q_FRAC;
  localparam int ACC_CW = $clog2(2 * WINDOW_LENGTH);
  localparam int CNT_W  = (ACC_CW > PROG_CNT_W) ? ACC_CW : PROG_CNT_W;

  state_t state_r, state_nxt;

  logic [TPS_W-1:0]         tps_r;
  logic [PIX_W-1:0]         cc_r;
  logic [PIX_W-1:0]         fh_r;

  logic [CNT_W-1:0]         cnt_r;
  logic                     found_r;
  logic [TW-1:0]            ts_r;
  logic [TW-1:0]            base_r;
  logic signed [XW-1:0]     cx_r;
  logic signed [XW-1:0]     fy_r;
  logic [VEL_W-1:0]         vel_r;

  logic signed [SD_W-1:0]   sd_r;
  logic signed [SX_W-1:0]   sx_r;
  logic signed [SDX_W-1:0]  sdx_r;
  logic [SDD_W-1:0]         sdd_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     num_neg_r;
  logic [NUM_W-1:0]         num_abs_r;
  logic [DEN_W-1:0]         den_r;

  logic                     issue;
  mop_t                     cur_op;
  logic                     issue_r;
  mop_t                     iop_r;

  logic signed [OPND_W-1:0] mul_a;
  logic signed [OPND_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [OPND_W-1:0] d;
  logic signed [OPND_W-1:0] absd;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_base;
  logic signed [ACC_W-1:0]  acc_nxt;

  logic signed [XW-1:0]     tap_x;
  logic [TW-1:0]            tap_t;
  win_ctrl_t                win_ctl;
  div_req_t                 div_req;
  logic                     div_done;
  logic [VEL_W-1:0]         div_quot;

  logic                     in_fire;
  logic [PIX_W-1:0]         in_px;
  logic [PIX_W-1:0]         in_py;
  logic [TW-1:0]            in_ts;
  logic signed [XW-1:0]     cx_calc;
  logic signed [XW-1:0]     fy_calc;

  // Input word unpacking.
  assign in_px    = in_tdata[10:0];
  assign in_py    = in_tdata[21:11];
  assign in_ts    = in_tdata[53:22];
  assign in_fire  = in_tvalid & in_tready;
  assign cx_calc  = signed'({1'b0, in_px}) - signed'({1'b0, cc_r});
  assign fy_calc  = signed'({1'b0, fh_r}) - signed'({1'b0, in_py});

  // Register file writes; writes to unused indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_W'(1000000);
      cc_r  <= PIX_W'(320);
      fh_r  <= PIX_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TPS:    tps_r <= cfg_data;
        REG_CENTRE: cc_r  <= cfg_data[PIX_W-1:0];
        REG_HEIGHT: fh_r  <= cfg_data[PIX_W-1:0];
        default:    ;
      endcase
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and sequencer outputs.
  always_comb begin
    state_nxt      = state_r;
    in_tready      = 1'b0;
    out_tvalid     = 1'b0;
    issue          = 1'b0;
    cur_op         = prog_op(cnt_r[PROG_CNT_W-1:0]);
    win_ctl.rotate = 1'b0;
    win_ctl.push   = 1'b0;
    div_req.start  = 1'b0;
    div_req.neg    = num_neg_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = in_tuser[0] ? ST_ACC : ST_SHIFT;
        end
      end
      ST_ACC: begin
        issue = 1'b1;
        if (cnt_r[0]) begin
          cur_op = '{a: A_ABSD, b: B_ABSD, sh: 2'd0, dst: DST_SDD, sub: 1'b0, clr: 1'b0,
                     save: SV_NONE};
          win_ctl.rotate = 1'b1;
        end else begin
          cur_op = '{a: A_D, b: B_X, sh: 2'd0, dst: DST_SDX, sub: 1'b0, clr: 1'b0,
                     save: SV_NONE};
        end
        if (cnt_r == CNT_W'(2 * WINDOW_LENGTH - 1)) begin
          state_nxt = ST_PROG;
        end
      end
      ST_PROG: begin
        issue = 1'b1;
        if (cnt_r == CNT_W'(PROG_LEN - 1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        if (den_r == '0) begin
          state_nxt = ST_SHIFT;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        win_ctl.push = 1'b1;
        state_nxt    = ST_OUT;
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Time offset of the tap sample from the oldest sample, and its magnitude.
  assign d    = signed'({1'b0, tap_t}) - signed'({1'b0, base_r});
  assign absd = d[OPND_W-1] ? -d : d;

  // Operand selection for the shared multiplier.
  always_comb begin
    case (cur_op.a)
      A_D:      mul_a = d;
      A_ABSD:   mul_a = absd;
      A_SDX_LO: mul_a = OPND_W'(sdx_r[LIMB_W-1:0]);
      A_SDX_HI: mul_a = OPND_W'(signed'(sdx_r[SDX_W-1:LIMB_W]));
      A_SD_LO:  mul_a = OPND_W'(sd_r[LIMB_W-1:0]);
      A_SD_HI:  mul_a = OPND_W'(signed'(sd_r[SD_W-1:LIMB_W]));
      A_SDD_L0: mul_a = OPND_W'(sdd_r[LIMB_W-1:0]);
      A_SDD_L1: mul_a = OPND_W'(sdd_r[2*LIMB_W-1:LIMB_W]);
      A_SDD_L2: mul_a = OPND_W'(sdd_r[SDD_W-1:2*LIMB_W]);
      A_NUM_LO: mul_a = OPND_W'(num_abs_r[LIMB_W-1:0]);
      A_NUM_HI: mul_a = OPND_W'(num_abs_r[NUM_W-1:LIMB_W]);
      default:  mul_a = '0;
    endcase
    case (cur_op.b)
      B_X:      mul_b = OPND_W'(tap_x);
      B_ABSD:   mul_b = absd;
      B_N:      mul_b = OPND_W'(WINDOW_LENGTH);
      B_SX:     mul_b = OPND_W'(sx_r);
      B_SD_LO:  mul_b = OPND_W'(sd_r[LIMB_W-1:0]);
      B_SD_HI:  mul_b = OPND_W'(signed'(sd_r[SD_W-1:LIMB_W]));
      B_TPS:    mul_b = OPND_W'(tps_r);
      default:  mul_b = '0;
    endcase
  end

  swve_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // The product lands in the cycle after issue; its slot travels alongside.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issue_r <= 1'b0;
    end else begin
      issue_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    iop_r <= cur_op;
  end

  // Limb-shifted accumulate into the wide register.
  always_comb begin
    prod_ext = ACC_W'(prod);
    case (iop_r.sh)
      2'd1:    term = prod_ext <<< LIMB_W;
      2'd2:    term = prod_ext <<< (2 * LIMB_W);
      default: term = prod_ext;
    endcase
    acc_base = iop_r.clr ? '0 : acc_r;
    acc_nxt  = iop_r.sub ? (acc_base - term) : (acc_base + term);
  end

  // Sums over the window and the wide accumulator.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sd_r  <= '0;
      sx_r  <= '0;
      sdx_r <= '0;
      sdd_r <= '0;
    end else begin
      if (issue && state_r == ST_ACC && !cnt_r[0]) begin
        sd_r <= sd_r + SD_W'(d);
        sx_r <= sx_r + SX_W'(tap_x);
      end
      if (issue_r) begin
        case (iop_r.dst)
          DST_SDX: sdx_r <= sdx_r + SDX_W'(prod);
          DST_SDD: sdd_r <= sdd_r + SDD_W'(prod);
          DST_ACC: acc_r <= acc_nxt;
          default: ;
        endcase
        case (iop_r.save)
          SV_NUM: begin
            num_neg_r <= acc_r[ACC_W-1];
            num_abs_r <= acc_r[ACC_W-1] ? NUM_W'(-acc_r) : NUM_W'(acc_r);
          end
          SV_DEN: den_r <= DEN_W'(acc_r);
          default: ;
        endcase
      end
    end
  end

  // Slot counter for the per-sample loop and the fixed program.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_fire) begin
      cnt_r <= '0;
    end else if (state_r == ST_ACC && cnt_r == CNT_W'(2 * WINDOW_LENGTH - 1)) begin
      cnt_r <= '0;
    end else if (state_r == ST_ACC || state_r == ST_PROG) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Captured word and result fields.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      found_r <= in_tuser[0];
      ts_r    <= in_ts;
      base_r  <= tap_t;
      cx_r    <= in_tuser[0] ? cx_calc : '0;
      fy_r    <= in_tuser[0] ? fy_calc : '0;
      vel_r   <= '0;
    end else if (state_r == ST_DIV && div_done) begin
      vel_r <= div_quot;
    end
  end

  swve_window #(
    .DEPTH (WINDOW_LENGTH)
  ) u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (win_ctl),
    .push_x (cx_r),
    .push_t (ts_r),
    .tap_x  (tap_x),
    .tap_t  (tap_t)
  );

  swve_div #(
    .DVD_W (DVD_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend ({acc_r[MAG_W-1:0], {Q_FRAC{1'b0}}}),
    .divisor  (den_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  // Result word packing.
  assign out_tdata = {vel_r, fy_r, cx_r};

  // The block never takes a word while a result is pending.
  assert property (@(posedge clk) disable iff (!rst_n) !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  // A word without a detection skips all arithmetic.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_tuser[0] |=> state_r == ST_SHIFT)
    else $error("undetected word entered the arithmetic path");

  // The divider reports completion only while the sequencer waits for it.
  assert property (@(posedge clk) disable iff (!rst_n) div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  // A result is offered only after the window has taken the new sample.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r) == ST_SHIFT)
    else $error("result offered before the window update");

  // The velocity and both coordinates are zero whenever the word carried no detection.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !found_r |-> vel_r == '0 && cx_r == '0 && fy_r == '0)
    else $error("nonzero result for an undetected word");

endmodule

### rtl/swve_mul.sv
module swve_mul import swve_pkg::*; (
  input  logic                     clk,
  input  logic signed [OPND_W-1:0] a,
  input  logic signed [OPND_W-1:0] b,
  output logic signed [PROD_W-1:0] prod
);

  // Shared signed multiplier with a registered product.
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

### rtl/swve_window.sv
module swve_window import swve_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  win_ctrl_t            ctl,
  input  logic signed [XW-1:0] push_x,
  input  logic [TW-1:0]        push_t,
  output logic signed [XW-1:0] tap_x,
  output logic [TW-1:0]        tap_t
);

  logic signed [XW-1:0] win_x_r [DEPTH];
  logic [TW-1:0]        win_t_r [DEPTH];

  // Rotation walks every entry past the tap and returns the window to its order;
  // a push drops the oldest entry and appends the new sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        win_x_r[i] <= '0;
        win_t_r[i] <= '0;
      end
    end else if (ctl.rotate) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        win_x_r[i] <= win_x_r[i+1];
        win_t_r[i] <= win_t_r[i+1];
      end
      win_x_r[DEPTH-1] <= win_x_r[0];
      win_t_r[DEPTH-1] <= win_t_r[0];
    end else if (ctl.push) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        win_x_r[i] <= win_x_r[i+1];
        win_t_r[i] <= win_t_r[i+1];
      end
      win_x_r[DEPTH-1] <= push_x;
      win_t_r[DEPTH-1] <= push_t;
    end
  end

  // The oldest entry is the only read port.
  assign tap_x = win_x_r[0];
  assign tap_t = win_t_r[0];

endmodule

### rtl/swve_div.sv
module swve_div import swve_pkg::*; #(
  parameter int DVD_W = 94,
  parameter int DEN_W = 73
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [VEL_W-1:0] quot
);

  localparam int CW = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CW-1:0]    cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [VEL_W:0]   q_r;
  logic             ovf_r;
  logic             neg_r;

  logic [DEN_W:0]   rem_sh;
  logic [DEN_W:0]   rem_sub;
  logic             ge;
  logic             big_pos;
  logic             big_neg;

  // One restoring step: bring down the next dividend bit and try the subtract.
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    ge      = (rem_sh >= {1'b0, den_r});
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath; only the low 33 quotient bits are kept, higher ones set a sticky flag.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      ovf_r <= 1'b0;
      neg_r <= req.neg;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      q_r   <= {q_r[VEL_W-1:0], ge};
      ovf_r <= ovf_r | q_r[VEL_W];
    end
  end

  // Sign and saturation of the quotient magnitude.
  always_comb begin
    big_pos = ovf_r | q_r[VEL_W] | q_r[VEL_W-1];
    big_neg = ovf_r | q_r[VEL_W] | (q_r[VEL_W-1] & (|q_r[VEL_W-2:0]));
    if (!neg_r) begin
      quot = big_pos ? VEL_MAX : q_r[VEL_W-1:0];
    end else begin
      quot = big_neg ? VEL_MIN : (VEL_W'(0) - q_r[VEL_W-1:0]);
    end
  end

  assign done = done_r;

endmodule
